// ----- design/skft_pkg.sv -----
// ----------------------------------------------------------------------------
// skft_pkg
// Types and constants shared by the sorted key / flag table.
// ----------------------------------------------------------------------------
package skft_pkg;

  localparam logic [2:0] OP_SET_LR    = 3'd0;
  localparam logic [2:0] OP_SET_FLAGS = 3'd1;
  localparam logic [2:0] OP_SET_BITS  = 3'd2;
  localparam logic [2:0] OP_CLR_BITS  = 3'd3;
  localparam logic [2:0] OP_OR_ALL    = 3'd4;
  localparam logic [2:0] OP_LOOKUP    = 3'd5;

  typedef struct packed {
    logic [2:0]         op;
    logic [31:0]        key;
    logic signed [31:0] msg_number;
    logic [31:0]        flag_value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] last_read;
    logic [31:0]        flags_out;
    logic               table_full;
  } rsp_t;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [31:0]        key;
    logic signed [31:0] last_read;
    logic [31:0]        flags;
  } entry_t;

  localparam rsp_t MISS_RSP = '{found: 1'b0, last_read: '1, flags_out: '1, table_full: 1'b0};

endpackage

// ----- design/skft_ram.sv -----
// ----------------------------------------------------------------------------
// skft_ram
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skft_ram
  import skft_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/skft_seq.sv -----
// ----------------------------------------------------------------------------
// skft_seq
// Sequencer: scans the sorted entries, updates in place, shifts on insert
// and sweeps the table for the OR-into-all operation.
// ----------------------------------------------------------------------------
module skft_seq
  import skft_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  req_t          req_i,
  input  logic [31:0]   default_flags_i,
  output logic          busy_o,
  output logic          done_o,
  output rsp_t          rsp_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output entry_t        wdata_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  entry_t        rdata_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_ORALL
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic          iss_q, iss_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic [AW-1:0] pos_q, pos_d;
  req_t          req_q, req_d;
  entry_t        new_q, new_d;
  rsp_t          rsp_q, rsp_d;

  logic          res;
  logic          hit;
  logic [CW-1:0] rpos;
  entry_t        upd;
  entry_t        ins;

  // Entry after an update of a present key.
  always_comb begin
    upd = rdata_i;
    case (req_q.op)
      OP_SET_LR:    upd.last_read = req_q.msg_number;
      OP_SET_FLAGS: upd.flags = req_q.flag_value;
      OP_SET_BITS:  upd.flags = rdata_i.flags | req_q.flag_value;
      OP_CLR_BITS:  upd.flags = rdata_i.flags & ~req_q.flag_value;
      default:      upd = rdata_i;
    endcase
  end

  // Entry for a key that is not yet present.
  always_comb begin
    ins.key       = req_q.key;
    ins.last_read = '1;
    ins.flags     = default_flags_i;
    case (req_q.op)
      OP_SET_LR:    ins.last_read = req_q.msg_number;
      OP_SET_FLAGS: ins.flags = req_q.flag_value;
      OP_SET_BITS:  ins.flags = default_flags_i | req_q.flag_value;
      OP_CLR_BITS:  ins.flags = default_flags_i & ~req_q.flag_value;
      default:      ins.flags = default_flags_i;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    iss_d   = iss_q;
    pend_d  = pend_q;
    idx_d   = idx_q;
    pidx_d  = pidx_q;
    pos_d   = pos_q;
    req_d   = req_q;
    new_d   = new_q;
    rsp_d   = rsp_q;
    we_o    = 1'b0;
    waddr_o = pidx_q;
    wdata_o = rdata_i;
    re_o    = 1'b0;
    raddr_o = idx_q;
    res     = 1'b0;
    hit     = 1'b0;
    rpos    = cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d  = req_i;
          idx_d  = '0;
          pend_d = 1'b0;
          iss_d  = (cnt_q != '0);
          if (req_i.op == OP_OR_ALL) begin
            state_d = ST_ORALL;
          end else if (req_i.op > OP_LOOKUP) begin
            rsp_d  = MISS_RSP;
            done_d = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (iss_q) begin
          re_o   = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q;
          if (CW'(idx_q) == (cnt_q - 1'b1)) begin
            iss_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          pend_d = 1'b0;
        end

        if (pend_q && (rdata_i.key >= req_q.key)) begin
          res  = 1'b1;
          hit  = (rdata_i.key == req_q.key);
          rpos = CW'(pidx_q);
        end else if (!iss_q && !pend_q) begin
          res = 1'b1;
        end

        if (res) begin
          re_o   = 1'b0;
          iss_d  = 1'b0;
          pend_d = 1'b0;
          if (hit) begin
            if (req_q.op != OP_LOOKUP) begin
              we_o    = 1'b1;
              waddr_o = pidx_q;
              wdata_o = upd;
            end
            rsp_d   = '{found: 1'b1, last_read: upd.last_read, flags_out: upd.flags,
                        table_full: 1'b0};
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else if (req_q.op == OP_LOOKUP) begin
            rsp_d   = MISS_RSP;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else if (cnt_q == CW'(DEPTH)) begin
            rsp_d            = MISS_RSP;
            rsp_d.table_full = 1'b1;
            done_d           = 1'b1;
            state_d          = ST_IDLE;
          end else if (rpos == cnt_q) begin
            // append at the end, nothing to move
            we_o    = 1'b1;
            waddr_o = AW'(cnt_q);
            wdata_o = ins;
            cnt_d   = cnt_q + 1'b1;
            rsp_d   = '{found: 1'b0, last_read: ins.last_read, flags_out: ins.flags,
                        table_full: 1'b0};
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            new_d   = ins;
            pos_d   = AW'(rpos);
            idx_d   = AW'(cnt_q - 1'b1);
            iss_d   = 1'b1;
            state_d = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        // move entries up by one, from the top down to the insert position
        if (pend_q) begin
          we_o    = 1'b1;
          waddr_o = pidx_q + 1'b1;
          wdata_o = rdata_i;
        end
        if (iss_q) begin
          re_o   = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q;
          if (idx_q == pos_q) begin
            iss_d = 1'b0;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end else begin
          pend_d = 1'b0;
        end
        if (!iss_q && !pend_q) begin
          we_o    = 1'b1;
          waddr_o = pos_q;
          wdata_o = new_q;
          cnt_d   = cnt_q + 1'b1;
          rsp_d   = '{found: 1'b0, last_read: new_q.last_read, flags_out: new_q.flags,
                      table_full: 1'b0};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_ORALL: begin
        if (pend_q) begin
          we_o          = 1'b1;
          waddr_o       = pidx_q;
          wdata_o       = rdata_i;
          wdata_o.flags = rdata_i.flags | req_q.flag_value;
        end
        if (iss_q) begin
          re_o   = 1'b1;
          pend_d = 1'b1;
          pidx_d = idx_q;
          if (CW'(idx_q) == (cnt_q - 1'b1)) begin
            iss_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          pend_d = 1'b0;
        end
        if (!iss_q && !pend_q) begin
          rsp_d   = MISS_RSP;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      iss_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pidx_q <= pidx_d;
    pos_q  <= pos_d;
    req_q  <= req_d;
    new_q  <= new_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- design/sorted_key_flag_table_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_flag_table_core
// Sorted key table holding a last-read number and a flag word per key.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low; its single result
// appears on rsp_o with done_o high for exactly one cycle and cannot be held
// off, so capture it on that cycle. Entries live in one memory with a
// registered read; the linear scan reads one entry per cycle. A hit or a miss
// ends the scan at the first entry whose key is not below the requested key,
// or past the end; an insert then shifts the higher entries up by one, and
// an OR into all entries reads and rewrites every entry; on an empty table a
// scan or a sweep reads nothing. The table needs no clearing pass after reset.
// default_flags is written through the cfg channel, which is always ready;
// write it only while busy is low.
module sorted_key_flag_table_core
  import skft_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  output logic        done_o,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0]   default_flags_q;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_flags_q <= '0;
    end else if (cfg_valid_i) begin
      default_flags_q <= cfg_data_i;
    end
  end

  skft_seq #(
    .DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .req_i          (req_i),
    .default_flags_i(default_flags_q),
    .busy_o         (busy),
    .done_o         (done_o),
    .rsp_o          (rsp_o),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata)
  );

  skft_ram #(
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule
